@@ src/srs_pkg.sv @@
// srs_pkg: shared types and constants for the step row sequencer
// request and result payload structs, op and kind codes, fsm state type
// no dependencies
`default_nettype none

package srs_pkg;

  localparam int MAX_VOICES       = 8;
  localparam int QUEUE_DEPTH      = 16;
  localparam int SAMPLES_PER_TICK = 512;
  localparam int SAMPLE_RATE      = 44100;

  localparam int LEVEL_W  = 4;
  localparam int ROW_W    = MAX_VOICES * LEVEL_W;
  localparam int QADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int VIDX_W   = 3;
  localparam int VCOUNT_W = 4;
  localparam int VOLUME_W = 7;
  localparam int BPM_W    = 11;
  localparam int PERIOD_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [BPM_W-1:0] BPM_MIN   = BPM_W'(21);
  localparam logic [BPM_W-1:0] BPM_MAX   = BPM_W'(2000);
  localparam int               BPM_RESET = 80;
  localparam int               PERIOD_MAX = 4095;

  // floor(a / (b * c)) == floor(floor(a / b) / c), so the tick size folds in here
  localparam int PERIOD_NUM   = (SAMPLE_RATE * 60) / SAMPLES_PER_TICK;
  localparam int NUM_W        = $clog2(PERIOD_NUM + 1);
  localparam int PERIOD_RAW80 = PERIOD_NUM / BPM_RESET;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET =
    PERIOD_W'((PERIOD_RAW80 > PERIOD_MAX) ? PERIOD_MAX : PERIOD_RAW80);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ELEM  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic KIND_TRIGGER = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BPM    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VOICES = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]         op;
    logic [LEVEL_W-1:0] voice_level;
    logic               row_last;
  } request_t;

  typedef struct packed {
    logic                kind;
    logic [VIDX_W-1:0]   voice_index;
    logic [VOLUME_W-1:0] volume;
    logic                more_to_play;
    logic                last;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

@@ src/srs_ram.sv @@
// srs_ram: generic single write port, single read port ram
// read data registered, held while rd_en is low; no dependencies
`default_nettype none

module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/srs_period_div.sv @@
// srs_period_div: step period from tempo by restoring division, one bit a cycle
// holds the step period register; depends on srs_pkg
`default_nettype none

module srs_period_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [srs_pkg::BPM_W-1:0]     divisor,
  output logic                               busy,
  output logic      [srs_pkg::PERIOD_W-1:0]  period
);
  import srs_pkg::*;

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam int SAT_W = (NUM_W > PERIOD_W) ? NUM_W : PERIOD_W;
  localparam logic [NUM_W-1:0] NUM_BITS = NUM_W'(PERIOD_NUM);

  logic [BPM_W-1:0] div_reg;
  logic [BPM_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] bit_idx;
  logic [BPM_W:0]   trial;
  logic             fits;
  logic [NUM_W-1:0] quo_next;
  logic [SAT_W-1:0] quo_wide;

  always_comb begin
    trial    = {rem, NUM_BITS[bit_idx]};
    fits     = trial >= {1'b0, div_reg};
    quo_next = {quo[NUM_W-2:0], fits};
    quo_wide = SAT_W'(quo_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      period <= PERIOD_RESET;
    end else if (load) begin
      busy    <= 1'b1;
      div_reg <= divisor;
      rem     <= '0;
      quo     <= '0;
      bit_idx <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      rem     <= fits ? BPM_W'(trial - {1'b0, div_reg}) : BPM_W'(trial);
      quo     <= quo_next;
      bit_idx <= bit_idx - 1'b1;
      if (bit_idx == '0) begin
        busy   <= 1'b0;
        period <= (quo_wide > SAT_W'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX)
                                                  : PERIOD_W'(quo_wide);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/step_row_sequencer.sv @@
// step_row_sequencer: tick driven step sequencer with a row queue in ram
// row element, flush, idle tick: busy stays low; a rejected row gives its result the
// cycle after. popping tick: ram read, then one voice a cycle; first trigger through
// the ram read and result registers; a tempo write holds busy while the divider runs.
// synchronous reset: queue empty, countdown 0, 80 bpm period, not playing; ram not cleared
// results come in the cycle after they are formed and cannot be held off
`default_nettype none

module step_row_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire srs_pkg::request_t               request,
  output logic                                 busy,
  output logic                                 result_valid,
  output srs_pkg::result_t                     result,
  input  wire logic                            cfg_write,
  input  wire logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srs_pkg::BPM_W-1:0]       cfg_data
);
  import srs_pkg::*;

  state_t              state, state_next;
  logic [QADDR_W-1:0]  head, head_next;
  logic [QCOUNT_W-1:0] count, count_next;
  logic [ROW_W-1:0]    asm_row, asm_row_next;
  logic [VCOUNT_W-1:0] asm_count, asm_count_next;
  logic [PERIOD_W-1:0] countdown, countdown_next;
  logic                playing, playing_next;
  logic [VCOUNT_W-1:0] voice_count, voice_count_next;
  logic [VIDX_W-1:0]   scan_idx, scan_idx_next;
  logic                result_valid_next;
  result_t             result_next;

  logic                accept;
  logic [VCOUNT_W-1:0] nv;
  logic [QADDR_W-1:0]  head_inc;
  logic [QADDR_W:0]    tail_sum;
  logic [QADDR_W-1:0]  tail;
  logic [ROW_W-1:0]    row_built;
  logic [LEVEL_W-1:0]  scan_level;
  logic                rest_nonzero;
  logic                bpm_load;
  logic                div_busy;
  logic [PERIOD_W-1:0] step_period;

  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [ROW_W-1:0]    ram_rd_data;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE) || div_busy;
  assign nv       = (voice_count > VCOUNT_W'(MAX_VOICES)) ? VCOUNT_W'(MAX_VOICES) : voice_count;
  assign bpm_load = cfg_write && (cfg_index == CFG_BPM) &&
                    (cfg_data >= BPM_MIN) && (cfg_data <= BPM_MAX);

  assign head_inc = (head == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = {1'b0, head} + (QADDR_W + 1)'(count);
  assign tail     = (tail_sum >= (QADDR_W + 1)'(QUEUE_DEPTH))
                    ? QADDR_W'(tail_sum - (QADDR_W + 1)'(QUEUE_DEPTH))
                    : QADDR_W'(tail_sum);

  // lane select for the row under assembly and for the row being played
  always_comb begin
    row_built    = asm_row;
    scan_level   = '0;
    rest_nonzero = 1'b0;
    for (int j = 0; j < MAX_VOICES; j++) begin
      if (asm_count < nv && VCOUNT_W'(j) == asm_count) begin
        row_built[j*LEVEL_W +: LEVEL_W] = request.voice_level;
      end
      if (VIDX_W'(j) == scan_idx) begin
        scan_level = ram_rd_data[j*LEVEL_W +: LEVEL_W];
      end
      if (j > int'(scan_idx) && VCOUNT_W'(j) < nv &&
          ram_rd_data[j*LEVEL_W +: LEVEL_W] != '0) begin
        rest_nonzero = 1'b1;
      end
    end
  end

  always_comb begin
    state_next        = state;
    head_next         = head;
    count_next        = count;
    asm_row_next      = asm_row;
    asm_count_next    = asm_count;
    countdown_next    = countdown;
    playing_next      = playing;
    voice_count_next  = voice_count;
    scan_idx_next     = scan_idx;
    result_valid_next = 1'b0;
    result_next       = '0;
    ram_wr_en         = 1'b0;
    ram_rd_en         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (request.op)
            OP_TICK: begin
              if (countdown != '0) begin
                countdown_next = countdown - 1'b1;
              end else begin
                countdown_next = step_period;
                if (count != '0) begin
                  ram_rd_en  = 1'b1;
                  head_next  = head_inc;
                  count_next = count - 1'b1;
                  if (nv != '0) begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                  end
                end else begin
                  playing_next = 1'b0;
                end
              end
            end
            OP_ELEM: begin
              if (asm_count < nv) begin
                asm_row_next   = row_built;
                asm_count_next = asm_count + 1'b1;
              end
              if (request.row_last) begin
                if (count == QCOUNT_W'(QUEUE_DEPTH)) begin
                  result_valid_next        = 1'b1;
                  result_next.kind         = KIND_REJECT;
                  result_next.more_to_play = playing;
                  result_next.last         = 1'b1;
                end else begin
                  ram_wr_en    = 1'b1;
                  count_next   = count + 1'b1;
                  playing_next = 1'b1;
                end
                asm_row_next   = '0;
                asm_count_next = '0;
              end
            end
            OP_FLUSH: begin
              head_next  = '0;
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_level != '0) begin
          result_valid_next        = 1'b1;
          result_next.kind         = KIND_TRIGGER;
          result_next.voice_index  = scan_idx;
          result_next.volume       = {scan_level, 3'b000};
          result_next.more_to_play = playing;
          result_next.last         = !rest_nonzero;
        end
        if ((VCOUNT_W'(scan_idx) + 1'b1) >= nv || !rest_nonzero) begin
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_write && cfg_index == CFG_VOICES) begin
      voice_count_next = cfg_data[VCOUNT_W-1:0];
      countdown_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      count        <= '0;
      asm_row      <= '0;
      asm_count    <= '0;
      countdown    <= '0;
      playing      <= 1'b0;
      voice_count  <= '0;
      scan_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      count        <= count_next;
      asm_row      <= asm_row_next;
      asm_count    <= asm_count_next;
      countdown    <= countdown_next;
      playing      <= playing_next;
      voice_count  <= voice_count_next;
      scan_idx     <= scan_idx_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  srs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_row_queue (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail),
    .wr_data (row_built),
    .rd_en   (ram_rd_en),
    .rd_addr (head),
    .rd_data (ram_rd_data)
  );

  srs_period_div u_period_div (
    .clk     (clk),
    .rst     (rst),
    .load    (bpm_load),
    .divisor (cfg_data),
    .busy    (div_busy),
    .period  (step_period)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for step_row_sequencer: directed and random requests checked against
// an in-bench model of the row queue, tempo countdown and voice triggers
// depends on srs_pkg and step_row_sequencer
`timescale 1ns / 100ps

module testbench;
  import srs_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 8;

  // op code with no meaning, expected to be ignored
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef enum logic [1:0] {
    PLAN_REQUEST,
    PLAN_CONFIG,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t             kind;
    request_t               req;
    logic [CFG_IDX_W-1:0]   idx;
    logic [BPM_W-1:0]       data;
    logic [6:0]             gap;
  } plan_entry_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  request_t             request = '0;
  logic                 busy;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BPM_W-1:0]     cfg_data = '0;

  step_row_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // sequencer model state
  logic [ROW_W-1:0]    row_store [QUEUE_DEPTH];
  logic [QADDR_W-1:0]  row_head;
  logic [QCOUNT_W-1:0] row_fill;
  logic [ROW_W-1:0]    build_row;
  logic [3:0]          build_count;
  logic [PERIOD_W-1:0] countdown;
  logic [PERIOD_W-1:0] step_period;
  logic                playing;
  logic [VCOUNT_W-1:0] voices;

  result_t     due_results [$];
  plan_entry_t plan [$];
  int          issued_count = 0;
  int          accepted_count = 0;
  int          quiet_cycles = 0;
  int          stall_cycles = 0;
  int          mismatches = 0;
  logic [6:0]  cur_gap = '0;

  function automatic logic [PERIOD_W-1:0] tempo_period(input logic [BPM_W-1:0] bpm);
    int p;
    p = (SAMPLE_RATE * 60) / (SAMPLES_PER_TICK * int'(bpm));
    if (p > PERIOD_MAX) p = PERIOD_MAX;
    return PERIOD_W'(p);
  endfunction

  function automatic request_t make_req(input logic [1:0] op, input int lvl,
                                        input logic fin);
    request_t r;
    r.op = op;
    r.voice_level = LEVEL_W'(lvl);
    r.row_last = fin;
    return r;
  endfunction

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [BPM_W-1:0] data);
    if (idx == CFG_BPM) begin
      // out of range tempo writes are dropped
      if (data >= BPM_MIN && data <= BPM_MAX) step_period = tempo_period(data);
    end else begin
      voices = data[VCOUNT_W-1:0];
      countdown = '0;
    end
  endtask

  task automatic advance_sequencer(input request_t r);
    int               nv;
    logic [3:0]       lv;
    logic [ROW_W-1:0] row;
    result_t          res;
    result_t          held;
    logic             have_held;
    nv = (int'(voices) > MAX_VOICES) ? MAX_VOICES : int'(voices);
    have_held = 1'b0;
    held = '0;
    case (r.op)
      OP_TICK: begin
        if (countdown != 0) begin
          countdown = countdown - 1'b1;
        end else begin
          countdown = step_period;
          if (row_fill != 0) begin
            row = row_store[row_head];
            row_head = row_head + 1'b1;
            row_fill = row_fill - 1'b1;
            for (int i = 0; i < nv; i++) begin
              lv = row[LEVEL_W*i +: LEVEL_W];
              if (lv != 0) begin
                if (have_held) due_results.insert(due_results.size(), held);
                res.kind = KIND_TRIGGER;
                res.voice_index = VIDX_W'(i);
                res.volume = VOLUME_W'({lv, 3'b000});
                res.more_to_play = playing;
                res.last = 1'b0;
                held = res;
                have_held = 1'b1;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              due_results.insert(due_results.size(), held);
            end
          end else begin
            playing = 1'b0;
          end
        end
      end
      OP_ELEM: begin
        if (int'(build_count) < nv) begin
          build_row = build_row | (ROW_W'(r.voice_level) << (LEVEL_W * build_count));
          build_count = build_count + 1'b1;
        end
        if (r.row_last) begin
          if (int'(row_fill) >= QUEUE_DEPTH) begin
            res.kind = KIND_REJECT;
            res.voice_index = '0;
            res.volume = '0;
            res.more_to_play = playing;
            res.last = 1'b1;
            due_results.insert(due_results.size(), res);
          end else begin
            row_store[QADDR_W'(row_head + row_fill)] = build_row;
            row_fill = row_fill + 1'b1;
            playing = 1'b1;
          end
          build_row = '0;
          build_count = '0;
        end
      end
      OP_FLUSH: begin
        row_head = '0;
        row_fill = '0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due, volume", got.volume, 0);
    end else begin
      want = due_results[0];
      due_results.delete(0);
      if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.voice_index != want.voice_index)
        report_mismatch("voice_index", got.voice_index, want.voice_index);
      if (got.volume != want.volume) report_mismatch("volume", got.volume, want.volume);
      if (got.more_to_play != want.more_to_play)
        report_mismatch("more_to_play", got.more_to_play, want.more_to_play);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  task automatic plan_request(input request_t r);
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_REQUEST;
    e.req = r;
    e.gap = cur_gap;
    plan.insert(plan.size(), e);
  endtask

  task automatic plan_config(input logic [CFG_IDX_W-1:0] idx, input int value);
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_CONFIG;
    e.idx = idx;
    e.data = BPM_W'(value);
    plan.insert(plan.size(), e);
  endtask

  task automatic plan_drain();
    plan_entry_t e;
    e = '0;
    e.kind = PLAN_DRAIN;
    plan.insert(plan.size(), e);
  endtask

  // mostly well formed rows and tick runs, some flushes, spare ops and stray elements
  task automatic plan_random(input int n_items);
    int count;
    int r;
    int k;
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(99);
      if (r < 38) begin
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++)
          plan_request(make_req(OP_ELEM, $urandom_range(15), i == k - 1));
        count += k;
      end else if (r < 82) begin
        k = $urandom_range(1, 8);
        repeat (k) plan_request(make_req(OP_TICK, $urandom_range(15), $urandom_range(1)));
        count += k;
      end else if (r < 88) begin
        plan_request(make_req(OP_FLUSH, $urandom_range(15), $urandom_range(1)));
        count++;
      end else if (r < 92) begin
        plan_request(make_req(OP_SPARE, $urandom_range(15), $urandom_range(1)));
      end else begin
        plan_request(make_req(OP_ELEM, $urandom_range(15), $urandom_range(1)));
        count++;
      end
    end
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin : drive
    plan_entry_t nxt;
    logic        go;
    logic        wr;
    go = 1'b0;
    wr = 1'b0;
    nxt = '0;
    if (!rst && !(start && issued_count != accepted_count)) begin
      if (plan.size() != 0) begin
        nxt = plan[0];
        case (nxt.kind)
          PLAN_REQUEST: begin
            if ($urandom_range(99) >= nxt.gap) begin
              plan.delete(0);
              go = 1'b1;
              issued_count++;
            end
          end
          PLAN_CONFIG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              plan.delete(0);
              wr = 1'b1;
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) plan.delete(0);
          end
        endcase
      end
      start <= go;
      cfg_write <= wr;
      if (go) request <= nxt.req;
      if (wr) begin
        cfg_index <= nxt.idx;
        cfg_data <= nxt.data;
      end
    end
  end

  // monitor: everything sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) check_result(result);
      if (start && !busy) begin
        advance_sequencer(request);
        accepted_count++;
      end
      if (cfg_write) apply_config(cfg_index, cfg_data);
      if (busy || start || cfg_write || result_valid || due_results.size() != 0)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid || (start && !busy) || cfg_write)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("step_row_sequencer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int bpm_tab [PHASES];
    int voice_tab [PHASES];
    int gap_tab [3];
    int long_row [9];

    bpm_tab = '{2000, 2047, 21, 20, 600, 0, 1500, 2001};
    voice_tab = '{8, 5, 8, 0, 15, 3, 1, 8};
    gap_tab = '{0, 59, 30};
    long_row = '{15, 8, 0, 1, 2, 3, 4, 5, 7};

    row_head = '0;
    row_fill = '0;
    build_row = '0;
    build_count = '0;
    countdown = '0;
    step_period = tempo_period(BPM_W'(BPM_RESET));
    playing = 1'b0;
    voices = '0;

    // directed: all voices, shortest period
    cur_gap = '0;
    plan_config(CFG_VOICES, 8);
    plan_config(CFG_BPM, 2000);
    // nine elements, the ninth dropped
    for (int i = 0; i < 9; i++) plan_request(make_req(OP_ELEM, long_row[i], i == 8));
    // silent row, then a short row padded with zeros
    plan_request(make_req(OP_ELEM, 0, 1'b1));
    plan_request(make_req(OP_ELEM, 6, 1'b1));
    // pop, countdown, silent pop, short pop, then expiry on an empty queue
    repeat (10) plan_request(make_req(OP_TICK, 0, 1'b0));
    plan_request(make_req(OP_SPARE, 15, 1'b1));
    plan_request(make_req(OP_ELEM, 3, 1'b1));
    plan_request(make_req(OP_FLUSH, 0, 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      cur_gap = 7'(gap_tab[ph % 3]);
      plan_config(CFG_BPM, (ph == 6) ? $urandom_range(21, 2000) : bpm_tab[ph]);
      plan_config(CFG_VOICES, voice_tab[ph]);
      if (ph == 4) begin
        // burst of one-element rows to overrun the queue
        repeat (18) plan_request(make_req(OP_ELEM, $urandom_range(15), 1'b1));
      end
      plan_random(14);
      // hold the sender back until every due result has come
      if (ph == 1) plan_drain();
      plan_random(14);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (plan.size() != 0 || start || cfg_write || busy || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("step_row_sequencer regression: pass");
    end else begin
      $display("step_row_sequencer regression: fail");
    end
    $finish;
  end

endmodule
